/* src/record_key_sorter_assert.svh */
// Assertion macros shared by the sorter checks.
`ifndef RECORD_KEY_SORTER_ASSERT_SVH
`define RECORD_KEY_SORTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorter check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorter check failed");

`endif

/* src/rks_pkg.sv */
package rks_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] KEY_INT   = 2'd0;
  localparam logic [1:0] KEY_FLOAT = 2'd1;

  localparam logic [1:0] CFG_KEY_TYPE   = 2'd0;
  localparam logic [1:0] CFG_DESCENDING = 2'd1;
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd2;

  typedef struct packed {
    logic [63:0] sort_key;
    logic [15:0] record_id;
    logic        batch_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_key;
    logic [15:0] out_record_id;
    logic        out_last;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [63:0]         sort_key;
    logic [ID_WIDTH-1:0] record_id;
  } entry_t;

endpackage

/* src/rks_order.sv */
// Map a key to an unsigned rank whose natural order is the emit order.
module rks_order (
  input  logic [63:0] sort_key,
  input  logic [1:0]  key_type,
  input  logic        descending,
  input  logic [3:0]  key_length,
  output logic [63:0] rank
);
  import rks_pkg::*;

  logic [31:0] fbits;
  logic [63:0] ov;
  logic [3:0]  len;
  logic        ended;
  logic [7:0]  kbyte;

  always_comb begin
    fbits = sort_key[31:0];
    ov    = '0;
    len   = (key_length > 4'd8) ? 4'd8 : key_length;
    ended = 1'b0;
    kbyte = '0;
    case (key_type)
      KEY_INT: begin
        ov = {32'd0, sort_key[31] ^ 1'b1, sort_key[30:0]};
      end
      KEY_FLOAT: begin
        if (fbits[30:0] == 31'd0) begin
          fbits = '0;
        end
        if (fbits[31]) begin
          ov = {32'd0, ~fbits};
        end else begin
          ov = {32'd0, fbits | 32'h8000_0000};
        end
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          kbyte = sort_key[63-8*i -: 8];
          if (ended || kbyte == 8'd0 || 4'(i) >= len) begin
            ended = 1'b1;
            kbyte = 8'd0;
          end
          ov[63-8*i -: 8] = kbyte;
        end
      end
    endcase
    rank = descending ? ~ov : ov;
  end

endmodule

/* src/record_key_sorter.sv */
// record_key_sorter: batch sort of (key, record id) items.
// in channel (in_valid/in_ready/in_data) takes one item per cycle while
// loading; each accepted item is written to a 64-entry buffer in load order.
// Items past capacity are dropped and flag overflow on the batch's results.
// The item with batch_end set closes the batch; input then stalls while
// results stream on out (out_valid/out_ready/out_data), ordered by key,
// ascending or descending, equal keys in load order. out_last marks the
// final result; after it is taken the block returns to loading.
// Each result costs one scan of the buffer through its single read port,
// so a batch of n stored items takes n scans; the first result follows
// one full scan of the buffer after the batch_end transaction.
// Key type, direction and key length are applied at emission time.
// While the receiver stalls the current result holds on out_data and
// no scan advances. Reset (rst, synchronous) empties the buffer, clears
// the drop flag and sets signed-int, ascending, key length 4.
// Configuration: cfg_we writes cfg_data to register cfg_index.
module record_key_sorter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rks_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rks_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data
);
  import rks_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_OUT} state_t;

  state_t state;

  // configuration
  logic [1:0] key_type;
  logic       descending;
  logic [3:0] key_length;

  // buffer
  entry_t mem [MAX_ENTRIES];
  entry_t rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] count;
  logic             dropped;
  logic [CNT_W-1:0] emitted;
  logic [CNT_W-1:0] iss;
  logic             rd_v;
  logic [IDX_W-1:0] rd_idx;

  // last emitted (rank, index) and best candidate of this scan
  logic             have_prev;
  logic [63:0]      prev_v;
  logic [IDX_W-1:0] prev_i;
  logic             have_best;
  logic [63:0]      best_v;
  logic [IDX_W-1:0] best_i;
  logic [63:0]      best_key;
  logic [ID_WIDTH-1:0] best_id;

  logic [63:0] rank;
  logic        after_prev;
  logic        before_best;
  logic        take;
  logic        in_fire;
  logic        store_ok;
  logic        scan_done;

  assign in_ready = (state == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign store_ok = (count < CNT_W'(MAX_ENTRIES));
  assign rd_addr  = iss[IDX_W-1:0];

  rks_order u_order (
    .sort_key  (rd_q.sort_key),
    .key_type  (key_type),
    .descending(descending),
    .key_length(key_length),
    .rank      (rank)
  );

  // Candidate must follow the previous result and precede the best so far.
  assign after_prev  = !have_prev || (rank > prev_v) ||
                       (rank == prev_v && rd_idx > prev_i);
  assign before_best = !have_best || (rank < best_v) ||
                       (rank == best_v && rd_idx < best_i);
  assign take        = rd_v && after_prev && before_best;
  assign scan_done   = rd_v && ({1'b0, rd_idx} == CNT_W'(count - 1'b1));

  always_ff @(posedge clk) begin
    if (in_fire && store_ok) begin
      mem[count[IDX_W-1:0]] <= '{sort_key: in_data.sort_key,
                                 record_id: ID_WIDTH'(in_data.record_id)};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_type   <= KEY_INT;
      descending <= 1'b0;
      key_length <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_TYPE:   key_type   <= cfg_data[1:0];
        CFG_DESCENDING: descending <= cfg_data[0];
        CFG_KEY_LENGTH: key_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      emitted   <= '0;
      iss       <= '0;
      rd_v      <= 1'b0;
      have_prev <= 1'b0;
      have_best <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (store_ok) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (in_data.batch_end) begin
              state     <= ST_SCAN;
              iss       <= '0;
              rd_v      <= 1'b0;
              have_prev <= 1'b0;
              have_best <= 1'b0;
              emitted   <= '0;
            end
          end
        end
        ST_SCAN: begin
          // issue reads in load order; read data returns through the rd_q register
          // (the last read is already issued when the scan completes)
          if (iss < count) begin
            iss    <= iss + 1'b1;
            rd_v   <= 1'b1;
            rd_idx <= iss[IDX_W-1:0];
          end else begin
            rd_v <= 1'b0;
          end
          if (take) begin
            have_best <= 1'b1;
            best_v    <= rank;
            best_i    <= rd_idx;
            best_key  <= rd_q.sort_key;
            best_id   <= rd_q.record_id;
          end
          if (scan_done) begin
            state     <= ST_OUT;
            out_valid <= 1'b1;
            out_data.out_key       <= take ? rd_q.sort_key : best_key;
            out_data.out_record_id <= 16'(take ? rd_q.record_id : best_id);
            out_data.out_last      <= (emitted + 1'b1 == count);
            out_data.overflow      <= dropped;
          end
        end
        ST_OUT: begin
          // hold the result until taken
          if (out_ready) begin
            out_valid <= 1'b0;
            if (emitted + 1'b1 == count) begin
              state   <= ST_LOAD;
              count   <= '0;
              dropped <= 1'b0;
            end else begin
              state     <= ST_SCAN;
              emitted   <= emitted + 1'b1;
              have_prev <= 1'b1;
              prev_v    <= best_v;
              prev_i    <= best_i;
              have_best <= 1'b0;
              iss       <= '0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* src/rks_checker.sv */
`include "record_key_sorter_assert.svh"

module rks_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rks_pkg::out_item_t out_data
);
  // a stalled result holds
  `RKS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // input stalls while a result is pending
  `RKS_ASSERT_NOW(a_no_load_on_out, out_valid, !in_ready)
  // closing the batch reopens the input
  `RKS_ASSERT_NEXT(a_reopen, out_valid && out_ready && out_data.out_last, in_ready)
  // a mid-batch result is followed by a fresh scan
  `RKS_ASSERT_NEXT(a_rescan, out_valid && out_ready && !out_data.out_last,
                   !out_valid && !in_ready)
endmodule

bind record_key_sorter rks_checker u_rks_checker (.*);

/* bench/tb_top.sv */
module tb_top;
  import rks_pkg::*;

  // Key type codes not named in the package.
  localparam logic [1:0] KEY_STRING = 2'd2;
  localparam logic [1:0] KEY_ALIAS3 = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  always #5 clk = ~clk;

  record_key_sorter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the sorter: registers, buffered batch, drop flag.
  logic [1:0]  pr_key_type;
  logic        pr_desc;
  logic [3:0]  pr_key_len;
  logic [63:0] batch_keys[$];
  logic [15:0] batch_ids[$];
  logic        batch_dropped;
  out_item_t   sorted_pending[$];

  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int batches_sent = 0;
  int hold_cycles = 0;   // receiver hold-off request, in cycles

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Map a key to an unsigned rank whose natural order is the key order.
  function automatic logic [63:0] key_rank(input logic [63:0] k);
    logic [31:0] b;
    logic [63:0] v;
    logic [7:0]  byt;
    bit          ended;
    int          len;
    v = '0;
    ended = 0;
    if (pr_key_type == KEY_INT)
      return {32'd0, k[31:0] ^ 32'h8000_0000};
    if (pr_key_type == KEY_FLOAT) begin
      b = k[31:0];
      if (b[30:0] == 0) b = '0;            // fold -0 onto +0
      if (b[31]) return {32'd0, ~b};
      return {32'd0, b | 32'h8000_0000};
    end
    len = (pr_key_len > 8) ? 8 : pr_key_len;
    for (int i = 0; i < len; i++) begin
      byt = k[63 - 8*i -: 8];
      if (ended || byt == 0) begin
        ended = 1;
        byt = 0;
      end
      v[63 - 8*i -: 8] = byt;
    end
    return v;
  endfunction

  // Accept one item into the predicted buffer; on batch end emit sorted order.
  task automatic predict_load(input in_item_t it);
    int order[$];
    int j, n;
    logic [63:0] rc, rp;
    out_item_t r;
    if (batch_keys.size() < MAX_ENTRIES) begin
      batch_keys = {batch_keys, it.sort_key};
      batch_ids = {batch_ids, it.record_id};
    end else begin
      batch_dropped = 1;
    end
    if (!it.batch_end) return;
    n = batch_keys.size();
    // stable insertion sort keeps equal keys in load order
    for (int i = 0; i < n; i++) begin
      j = order.size();
      rc = key_rank(batch_keys[i]);
      while (j > 0) begin
        rp = key_rank(batch_keys[order[j-1]]);
        if (pr_desc ? (rc > rp) : (rc < rp)) j--;
        else break;
      end
      order.insert(j, i);
    end
    for (int i = 0; i < n; i++) begin
      r.out_key = batch_keys[order[i]];
      r.out_record_id = batch_ids[order[i]];
      r.out_last = (i == n - 1);
      r.overflow = batch_dropped;
      sorted_pending = {sorted_pending, r};
    end
    batch_keys.delete();
    batch_ids.delete();
    batch_dropped = 0;
  endtask

  // Random gap: mostly short, now and then long, often none.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  bit sender_idle = 0;  // when set, random gaps go between transactions

  // Offer one item; hold it until the transaction completes.
  // Valid stays up after acceptance until the next call or an idle request.
  task automatic send_item(input logic [63:0] k, input logic [15:0] id,
                           input logic last);
    int g;
    in_item_t it;
    g = sender_idle ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.sort_key = k;
    it.record_id = id;
    it.batch_end = last;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_load(it);
    items_sent++;
    if (last) batches_sent++;
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_KEY_TYPE:   pr_key_type = val[1:0];
      CFG_DESCENDING: pr_desc = val[0];
      CFG_KEY_LENGTH: pr_key_len = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sorted_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] kt, input logic d,
                            input logic [3:0] len);
    drain_results();
    write_reg(CFG_KEY_TYPE, {2'b00, kt});
    write_reg(CFG_DESCENDING, {3'b000, d});
    write_reg(CFG_KEY_LENGTH, len);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Keys with many ties and interesting values for the current key type.
  function automatic logic [63:0] pick_key();
    int p;
    logic [63:0] k;
    p = $urandom_range(0, 9);
    k = rand_key();
    case (p)
      0: k[31:0] = $urandom_range(0, 3);             // ties
      1: k[31:0] = {1'b1, 31'd0};                    // min int / -0.0
      2: k[31:0] = 32'h7F80_0000 | $urandom_range(0, 1);   // inf / NaN
      3: k[31:0] = 32'hFF80_0000 | $urandom_range(0, 1);
      4: k[63:48] = {8'h41, 8'h00};                  // string ends early
      5: k[63:40] = {8'h41, 8'h42, 8'h00};
      default: ;
    endcase
    return k;
  endfunction

  task automatic send_batch(input int n);
    for (int i = 0; i < n; i++)
      send_item(pick_key(), 16'($urandom()), i == n - 1);
  endtask

  // Each key type, both directions, and key lengths at the extremes.
  task automatic test_directed();
    set_config(KEY_INT, 1'b0, 4'd4);
    send_item(64'hFFFF_FFFF_8000_0000, 16'hFFFF, 1'b0);
    send_item(64'h0000_0000_7FFF_FFFF, 16'h0000, 1'b0);
    send_item(64'h1234_5678_0000_0000, 16'h0001, 1'b0);
    send_item(64'h0, 16'h0002, 1'b1);
    set_config(KEY_FLOAT, 1'b1, 4'd4);
    send_item(64'h8000_0000, 16'd1, 1'b0);           // -0
    send_item(64'h0000_0000, 16'd2, 1'b0);           // +0 ties with -0
    send_item(64'h7F80_0000, 16'd3, 1'b0);           // +inf
    send_item(64'h7FC0_0001, 16'd4, 1'b0);           // +NaN
    send_item(64'hFFC0_0000, 16'd5, 1'b0);           // -NaN
    send_item(64'hFF80_0000, 16'd6, 1'b0);           // -inf
    send_item(64'h3F80_0000, 16'd7, 1'b1);
    set_config(KEY_STRING, 1'b0, 4'd8);
    send_item(64'h4142_0043_4444_4444, 16'd1, 1'b0);
    send_item(64'h4142_0000_0000_0000, 16'd2, 1'b0);
    send_item(64'hFF00_0000_0000_0001, 16'd3, 1'b0);
    send_item(64'h4142_4300_0000_0000, 16'd4, 1'b1);
    set_config(KEY_ALIAS3, 1'b1, 4'd15);             // above 8 acts as 8
    send_item(64'h0102_0304_0506_0708, 16'd1, 1'b0);
    send_item(64'h0102_0304_0506_0709, 16'd2, 1'b1);
    set_config(KEY_STRING, 1'b0, 4'd0);              // all keys equal
    send_item(64'hFF, 16'd1, 1'b0);
    send_item(64'h01, 16'd2, 1'b0);
    send_item(64'h80, 16'd3, 1'b1);
    set_config(KEY_STRING, 1'b1, 4'd1);
    send_item(64'h0100_0000_0000_0000, 16'd1, 1'b1); // single-item batch
  endtask

  // Fill beyond capacity, also with the closing item itself dropped.
  task automatic test_overflow();
    set_config(KEY_INT, 1'b1, 4'd4);
    send_batch(MAX_ENTRIES + 3);
    set_config(KEY_FLOAT, 1'b0, 4'd4);
    send_batch(MAX_ENTRIES + 1);
    send_batch(MAX_ENTRIES);
  endtask

  // Receiver holds off while a batch is loaded and emitting.
  task automatic test_backpressure();
    set_config(KEY_INT, 1'b0, 4'd4);
    hold_cycles = 300;
    send_batch(10);
    send_batch(5);
    drain_results();
  endtask

  // Random batches, mostly small, under random settings.
  task automatic test_random();
    int n;
    while (items_sent < 430) begin
      set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
      sender_idle = $urandom_range(0, 3) != 0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      send_batch(n);
    end
  endtask

  // Receiver: random ready, with a long hold-off when requested.
  bit sink_idle = 1;
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (sink_idle && gap_len() != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check each result transaction against the oldest expectation.
  out_item_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (sorted_pending.size() == 0) begin
        report($sformatf("unexpected result key=%h", out_data.out_key));
      end else begin
        want = sorted_pending.pop_front();
        if (out_data.out_key !== want.out_key)
          report($sformatf("out_key %h, want %h", out_data.out_key, want.out_key));
        if (out_data.out_record_id !== want.out_record_id)
          report($sformatf("out_record_id %h, want %h",
                           out_data.out_record_id, want.out_record_id));
        if (out_data.out_last !== want.out_last)
          report($sformatf("out_last %b, want %b", out_data.out_last, want.out_last));
        if (out_data.overflow !== want.overflow)
          report($sformatf("overflow %b, want %b", out_data.overflow, want.overflow));
      end
    end
  end

  initial begin
    pr_key_type = KEY_INT;
    pr_desc = 1'b0;
    pr_key_len = 4'd4;
    batch_dropped = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    sender_idle = 1;
    test_random();
    drain_results();
    repeat (200) @(posedge clk);
    $display("Covered %0d items in %0d batches, %0d sorted results checked,",
             items_sent, batches_sent, results_seen);
    $display("all key types, both directions, key lengths 0..15, overflow and stalls.");
    if (error_count == 0 && sorted_pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Worst case: ~500 items, batches up to 64 with one buffer scan per result, stalls.
  initial begin
    #20_000_000;
    $display("TIMEOUT waiting on the sorter");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/rks_pkg.sv
src/rks_order.sv
src/record_key_sorter.sv
src/rks_checker.sv
bench/tb_top.sv
